@@ rtl/mpab_pkg.sv @@
// Shared types and constants for the masked pixel alpha blend core.
package mpab_pkg;

    localparam int PIX_W   = 32;
    localparam int ALPHA_W = 8;
    localparam int CMD_W   = 4;
    localparam int SHIFT_W = 5;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_PIXELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHIFT = 3'd5;

    // Reset values
    localparam logic               RST_WIDE_PIXELS = 1'b1;
    localparam logic [PIX_W-1:0]   RST_RED_MASK    = 32'h00FF_0000;
    localparam logic [PIX_W-1:0]   RST_GREEN_MASK  = 32'h0000_FF00;
    localparam logic [PIX_W-1:0]   RST_BLUE_MASK   = 32'h0000_00FF;
    localparam logic [PIX_W-1:0]   RST_ALPHA_MASK  = 32'hFF00_0000;
    localparam logic [SHIFT_W-1:0] RST_ALPHA_SHIFT = 5'd24;

    // Blend modes (32-bit pixels)
    localparam logic [CMD_W-1:0] MODE_BLEND_COMBINE = 4'd0;
    localparam logic [CMD_W-1:0] MODE_BLEND_DEST_A  = 4'd1;
    localparam logic [CMD_W-1:0] MODE_BLEND_SRC_A   = 4'd2;
    localparam logic [CMD_W-1:0] MODE_COPY_SRC_A    = 4'd3;
    localparam logic [CMD_W-1:0] MODE_COPY_DEST_A   = 4'd4;
    localparam logic [CMD_W-1:0] MODE_COPY_COMBINE  = 4'd5;
    localparam logic [CMD_W-1:0] MODE_COPY_OPAQUE   = 4'd6;
    localparam logic [CMD_W-1:0] MODE_KEEP_SRC_A    = 4'd7;
    localparam logic [CMD_W-1:0] MODE_KEEP_COMBINE  = 4'd8;
    localparam logic [CMD_W-1:0] MODE_KEEP_COND     = 4'd9;

    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        COL_BLEND,
        COL_COPY,
        COL_KEEP
    } colour_sel_t;

    typedef enum logic [2:0] {
        AL_ZERO,
        AL_COMBINED,
        AL_DEST,
        AL_SRC,
        AL_OPAQUE,
        AL_COND
    } alpha_sel_t;

    typedef struct packed {
        logic               wide_pixels;
        logic [PIX_W-1:0]   red_mask;
        logic [PIX_W-1:0]   green_mask;
        logic [PIX_W-1:0]   blue_mask;
        logic [PIX_W-1:0]   alpha_mask;
        logic [SHIFT_W-1:0] alpha_shift;
    } cfg_t;

endpackage

@@ rtl/mpab_chan.sv @@
// One masked channel blend: (d&m) + (((s&m) - (d&m)) * a >> 8), masked, 32-bit wrap.
module mpab_chan (
    input  logic [mpab_pkg::PIX_W-1:0]   dest,
    input  logic [mpab_pkg::PIX_W-1:0]   src,
    input  logic [mpab_pkg::PIX_W-1:0]   mask,
    input  logic [mpab_pkg::ALPHA_W-1:0] alpha,
    output logic [mpab_pkg::PIX_W-1:0]   mixed
);
    import mpab_pkg::*;

    logic [PIX_W-1:0]         dm;
    logic [PIX_W-1:0]         sm;
    logic [PIX_W-1:0]         diff;
    logic [PIX_W-1:0]         prod;
    logic [PIX_W-1:0]         scaled;

    always_comb
    begin
        dm     = dest & mask;
        sm     = src & mask;
        diff   = sm - dm;
        // product wraps at 32 bits before the shift
        prod   = diff * {24'b0, alpha};
        scaled = {8'b0, prod[PIX_W-1:8]};
        mixed  = (dm + scaled) & mask;
    end

endmodule

@@ rtl/mpab_datapath.sv @@
// Mode decode and channel assembly for one pixel.
module mpab_datapath (
    input  mpab_pkg::cfg_t               cfg,
    input  logic [mpab_pkg::CMD_W-1:0]   cmd,
    input  logic [mpab_pkg::PIX_W-1:0]   dest_pixel,
    input  logic [mpab_pkg::PIX_W-1:0]   src_color,
    input  logic [mpab_pkg::ALPHA_W-1:0] alpha,
    output logic [mpab_pkg::PIX_W-1:0]   new_pixel
);
    import mpab_pkg::*;

    logic [PIX_W-1:0] d_use;
    logic [PIX_W-1:0] mix_r;
    logic [PIX_W-1:0] mix_g;
    logic [PIX_W-1:0] mix_b;
    logic [PIX_W-1:0] mix_a;
    logic [PIX_W-1:0] destal;
    logic [PIX_W-1:0] combined_sum;
    logic [PIX_W-1:0] combined;
    logic [PIX_W-1:0] srcal;
    logic [PIX_W-1:0] opaqueal;
    logic [PIX_W-1:0] al;
    logic [PIX_W-1:0] rgb_mask;
    logic [PIX_W-1:0] colour;
    logic [PIX_W-1:0] narrow_pix;
    colour_sel_t      col_sel;
    alpha_sel_t       al_sel;

    // narrow pixels use only the low half of the destination
    assign d_use = cfg.wide_pixels ? dest_pixel : {16'b0, dest_pixel[15:0]};

    mpab_chan u_red   (.dest(d_use), .src(src_color), .mask(cfg.red_mask),
                       .alpha(alpha), .mixed(mix_r));
    mpab_chan u_green (.dest(d_use), .src(src_color), .mask(cfg.green_mask),
                       .alpha(alpha), .mixed(mix_g));
    mpab_chan u_blue  (.dest(d_use), .src(src_color), .mask(cfg.blue_mask),
                       .alpha(alpha), .mixed(mix_b));
    mpab_chan u_alpha (.dest(d_use), .src(src_color), .mask(cfg.alpha_mask),
                       .alpha(alpha), .mixed(mix_a));

    always_comb
    begin
        col_sel = COL_COPY;
        al_sel  = AL_ZERO;
        unique case (cmd)
            MODE_BLEND_COMBINE: begin col_sel = COL_BLEND; al_sel = AL_COMBINED; end
            MODE_BLEND_DEST_A:  begin col_sel = COL_BLEND; al_sel = AL_DEST;     end
            MODE_BLEND_SRC_A:   begin col_sel = COL_BLEND; al_sel = AL_SRC;      end
            MODE_COPY_SRC_A:    begin col_sel = COL_COPY;  al_sel = AL_SRC;      end
            MODE_COPY_DEST_A:   begin col_sel = COL_COPY;  al_sel = AL_DEST;     end
            MODE_COPY_COMBINE:  begin col_sel = COL_COPY;  al_sel = AL_COMBINED; end
            MODE_COPY_OPAQUE:   begin col_sel = COL_COPY;  al_sel = AL_OPAQUE;   end
            MODE_KEEP_SRC_A:    begin col_sel = COL_KEEP;  al_sel = AL_SRC;      end
            MODE_KEEP_COMBINE:  begin col_sel = COL_KEEP;  al_sel = AL_COMBINED; end
            MODE_KEEP_COND:     begin col_sel = COL_KEEP;  al_sel = AL_COND;     end
            default:            begin col_sel = COL_COPY;  al_sel = AL_ZERO;     end
        endcase
    end

    always_comb
    begin
        destal       = dest_pixel & cfg.alpha_mask;
        combined_sum = (destal >> cfg.alpha_shift) + {24'b0, alpha};
        combined     = (combined_sum >> 1) << cfg.alpha_shift;
        srcal        = {24'b0, alpha} << cfg.alpha_shift;
        opaqueal     = {24'b0, ALPHA_OPAQUE} << cfg.alpha_shift;

        case (al_sel)
            AL_COMBINED: al = combined;
            AL_DEST:     al = destal;
            AL_SRC:      al = srcal;
            AL_OPAQUE:   al = opaqueal;
            AL_COND:     al = (destal == '0 || alpha == '0) ? '0 : combined;
            default:     al = '0;
        endcase
        if (cfg.alpha_mask == '0)
            al = '0;

        rgb_mask = cfg.red_mask | cfg.green_mask | cfg.blue_mask;
        if (col_sel == COL_BLEND && alpha != ALPHA_OPAQUE)
            colour = mix_r | mix_g | mix_b;
        else if (col_sel == COL_KEEP)
            colour = dest_pixel & rgb_mask;
        else
            colour = src_color & rgb_mask;

        // a zero alpha mask makes mix_a zero on its own
        narrow_pix = {16'b0, 16'(mix_r | mix_g | mix_b | mix_a)};
        new_pixel  = cfg.wide_pixels ? (colour | al) : narrow_pix;
    end

endmodule

@@ rtl/masked_pixel_alpha_blend_core.sv @@
// Top level of the masked pixel alpha blend core: registers, handshake and config.
//
// Blends one packed pixel per word: each word carries a blend mode (cmd), the
// destination pixel, the source color and an 8-bit alpha, and yields one packed
// new_pixel. The core is a two-register pipeline: an input register captures the
// word, one pass of logic (four 32x8 channel multipliers, mode decode and the
// alpha-channel shifts) feeds the result register. It takes one word every clock
// cycle while in_stall is low, and its result is registered; the single pass of
// channel multipliers sets the clock period. in_stall rises only when both
// registers hold words and out_stall is high, so up to two words sit inside
// while the output is held off. Channel masks, alpha position and pixel width
// come from the cfg_we/cfg_index/cfg_data port (index 0 wide_pixels, 1 red,
// 2 green, 3 blue, 4 alpha masks, 5 alpha_shift); writes to other indexes are
// dropped. Change them only while no word is inside the core.
module masked_pixel_alpha_blend_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mpab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mpab_pkg::PIX_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mpab_pkg::CMD_W-1:0]         cmd,
    input  logic [mpab_pkg::PIX_W-1:0]         dest_pixel,
    input  logic [mpab_pkg::PIX_W-1:0]         src_color,
    input  logic [mpab_pkg::ALPHA_W-1:0]       alpha,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mpab_pkg::PIX_W-1:0]         new_pixel
);
    import mpab_pkg::*;

    cfg_t               cfg_reg;
    logic               s1_valid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [PIX_W-1:0]   dest_reg;
    logic [PIX_W-1:0]   src_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               s2_valid_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   pix_next;
    logic               in_take;
    logic               s2_load;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wide_pixels <= RST_WIDE_PIXELS;
            cfg_reg.red_mask    <= RST_RED_MASK;
            cfg_reg.green_mask  <= RST_GREEN_MASK;
            cfg_reg.blue_mask   <= RST_BLUE_MASK;
            cfg_reg.alpha_mask  <= RST_ALPHA_MASK;
            cfg_reg.alpha_shift <= RST_ALPHA_SHIFT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDE_PIXELS: cfg_reg.wide_pixels <= cfg_data[0];
                CFG_RED_MASK:    cfg_reg.red_mask    <= cfg_data;
                CFG_GREEN_MASK:  cfg_reg.green_mask  <= cfg_data;
                CFG_BLUE_MASK:   cfg_reg.blue_mask   <= cfg_data;
                CFG_ALPHA_MASK:  cfg_reg.alpha_mask  <= cfg_data;
                CFG_ALPHA_SHIFT: cfg_reg.alpha_shift <= cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Handshake: stage 2 loads a word from stage 1 whenever it is empty or being drained
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;

            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (!out_stall)
                s2_valid_reg <= 1'b0;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= cmd;
            dest_reg  <= dest_pixel;
            src_reg   <= src_color;
            alpha_reg <= alpha;
        end
    end

    mpab_datapath u_datapath (
        .cfg        (cfg_reg),
        .cmd        (cmd_reg),
        .dest_pixel (dest_reg),
        .src_color  (src_reg),
        .alpha      (alpha_reg),
        .new_pixel  (pix_next)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (s2_load)
            pix_reg <= pix_next;
    end

    assign out_valid = s2_valid_reg;
    assign new_pixel = pix_reg;

    // Stall toward the source only when both registers are occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_stall))
        else $error("in_stall raised with a free register");

    // An accepted word always lands in the input register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted word lost");

    // A blocked input word holds its payload
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=>
            (s1_valid_reg && $stable(dest_reg) && $stable(src_reg)
             && $stable(cmd_reg) && $stable(alpha_reg)))
        else $error("input register changed while blocked");

    // Narrow pixel results keep the upper half clear
    a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && !cfg_reg.wide_pixels) |=> (new_pixel[31:16] == 16'h0000))
        else $error("narrow pixel result has upper bits set");

endmodule

@@ bench/tb_masked_pixel_alpha_blend_core.sv @@
// Self-checking testbench for the masked pixel alpha blend core.
module tb_masked_pixel_alpha_blend_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mpab_pkg::*;

    // Modes 10..15 have no meaning in 32-bit mode: masked source, alpha zero
    localparam logic [CMD_W-1:0]     MODE_UNDEFINED_FIRST = 4'd10;
    localparam logic [CMD_W-1:0]     MODE_UNDEFINED_LAST  = 4'd15;
    // Register index with no register behind it; writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE            = 3'd6;

    localparam int WORDS_PER_PHASE = 24;
    localparam int SETTING_COUNT   = 10;
    localparam int HOLD_CYCLES     = 200;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One directed row: a pixel word, or a register write (index in code,
    // data in dest). known marks rows whose result is typed in below.
    typedef struct packed {
        row_kind_t          kind;
        logic [CMD_W-1:0]   code;
        logic [PIX_W-1:0]   dest;
        logic [PIX_W-1:0]   src;
        logic [ALPHA_W-1:0] alpha;
        logic               known;
        logic [PIX_W-1:0]   pixel;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PIX_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd = '0;
    logic [PIX_W-1:0]     dest_pixel = '0;
    logic [PIX_W-1:0]     src_color = '0;
    logic [ALPHA_W-1:0]   alpha = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     new_pixel;

    // Sideband travelling with the payload: a typed-in result for this word
    logic                 has_typed_pixel = 1'b0;
    logic [PIX_W-1:0]     typed_pixel = '0;

    idle_mode_t           idle_mode = IDLE_NONE;
    logic                 hold_go = 1'b0;
    logic                 hold_off = 1'b0;

    // Shadow of the core's registers, updated on every write we issue
    cfg_t cfg_shadow = '{wide_pixels: RST_WIDE_PIXELS, red_mask: RST_RED_MASK,
                         green_mask: RST_GREEN_MASK, blue_mask: RST_BLUE_MASK,
                         alpha_mask: RST_ALPHA_MASK, alpha_shift: RST_ALPHA_SHIFT};

    logic [PIX_W-1:0] pending_pixels [$];
    int mismatch_count = 0;
    int words_sent = 0;
    int pixels_checked = 0;

    masked_pixel_alpha_blend_core DUT (.*);

    // Directed part. Starts at the reset format (ARGB, alpha at bit 24), then
    // alpha-less, then an alpha mask covering the whole word with shift 31 so
    // the alpha shifts wrap, then 16-bit RGB565, then overlapping masks.
    row_t directed_rows [33] = '{
        '{ROW_WORD, MODE_COPY_SRC_A,      32'h00000000, 32'hFFFFFFFF, 8'hFF, 1'b1, 32'hFFFFFFFF},
        '{ROW_WORD, MODE_KEEP_SRC_A,      32'h12345678, 32'hFFFFFFFF, 8'h00, 1'b1, 32'h00345678},
        // opaque alpha skips the color blend
        '{ROW_WORD, MODE_BLEND_COMBINE,   32'h00000000, 32'hFFFFFFFF, 8'hFF, 1'b1, 32'h7FFFFFFF},
        '{ROW_WORD, MODE_BLEND_SRC_A,     32'hAABBCCDD, 32'h11223344, 8'h00, 1'b1, 32'h00BBCCDD},
        '{ROW_WORD, MODE_COPY_OPAQUE,     32'h00000000, 32'h00123456, 8'h00, 1'b1, 32'hFF123456},
        '{ROW_WORD, MODE_UNDEFINED_FIRST, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h80, 1'b1, 32'h00FFFFFF},
        '{ROW_WORD, MODE_UNDEFINED_LAST,  32'h00000000, 32'hFFFFFFFF, 8'h00, 1'b1, 32'h00FFFFFF},
        // conditional keep: zero dest alpha, zero alpha, then both set
        '{ROW_WORD, MODE_KEEP_COND,       32'h00ABCDEF, 32'h00000000, 8'h80, 1'b1, 32'h00ABCDEF},
        '{ROW_WORD, MODE_KEEP_COND,       32'hFF000000, 32'h00000000, 8'h00, 1'b1, 32'h00000000},
        '{ROW_WORD, MODE_KEEP_COND,       32'hFF000000, 32'h00000000, 8'hFF, 1'b1, 32'hFF000000},
        '{ROW_WORD, MODE_COPY_DEST_A,     32'hFFFFFFFF, 32'h00000000, 8'h55, 1'b1, 32'hFF000000},
        '{ROW_WORD, MODE_BLEND_DEST_A,    32'h80FFFFFF, 32'h00000000, 8'h80, 1'b0, 32'h0},
        '{ROW_WORD, MODE_COPY_COMBINE,    32'h40102030, 32'hC0A0B0C0, 8'h7F, 1'b0, 32'h0},
        '{ROW_WORD, MODE_KEEP_COMBINE,    32'hFFFFFFFF, 32'h00000000, 8'hFF, 1'b1, 32'hFFFFFFFF},
        '{ROW_WORD, MODE_BLEND_COMBINE,   32'h00000000, 32'hFFFFFFFF, 8'h01, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_SPARE),       32'hFFFFFFFF, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_ALPHA_MASK),  32'h00000000, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_WORD, MODE_COPY_OPAQUE,     32'h00000000, 32'hFFFFFFFF, 8'h00, 1'b1, 32'h00FFFFFF},
        '{ROW_REG,  CMD_W'(CFG_ALPHA_MASK),  32'hFFFFFFFF, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_ALPHA_SHIFT), 32'h0000001F, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_WORD, MODE_COPY_SRC_A,      32'h00000000, 32'h00000000, 8'hFF, 1'b1, 32'h80000000},
        '{ROW_WORD, MODE_BLEND_COMBINE,   32'hFFFFFFFF, 32'h12345678, 8'hC3, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_WIDE_PIXELS), 32'h00000000, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_RED_MASK),    32'h0000F800, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_GREEN_MASK),  32'h000007E0, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_BLUE_MASK),   32'h0000001F, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_ALPHA_MASK),  32'h00000000, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_REG,  CMD_W'(CFG_ALPHA_SHIFT), 32'h00000000, 32'h0, 8'h0, 1'b0, 32'h0},
        // 16-bit: upper dest bits dropped, mode ignored
        '{ROW_WORD, MODE_BLEND_COMBINE,   32'hFFFF0000, 32'h00000000, 8'h80, 1'b1, 32'h00000000},
        '{ROW_WORD, MODE_COPY_OPAQUE,     32'h00001234, 32'hFFFFFFFF, 8'h00, 1'b1, 32'h00001234},
        '{ROW_WORD, MODE_KEEP_COND,       32'h00000000, 32'hFFFFFFFF, 8'hFF, 1'b0, 32'h0},
        // alpha mask overlapping red: channel results just OR together
        '{ROW_REG,  CMD_W'(CFG_ALPHA_MASK),  32'h0000F000, 32'h0, 8'h0, 1'b0, 32'h0},
        '{ROW_WORD, MODE_BLEND_COMBINE,   32'h1234ABCD, 32'hFFFF0000, 8'h40, 1'b0, 32'h0}
    };

    // One channel: masked dest plus the weighted masked difference, all in
    // 32-bit wrapping arithmetic, masked again at the end.
    function automatic logic [PIX_W-1:0] weigh_channel(input logic [PIX_W-1:0] d,
                                                       input logic [PIX_W-1:0] s,
                                                       input logic [PIX_W-1:0] m,
                                                       input logic [ALPHA_W-1:0] a);
        logic [PIX_W-1:0] dm;
        logic [PIX_W-1:0] sm;
        logic [PIX_W-1:0] diff;
        logic [PIX_W-1:0] prod;
        dm = d & m;
        sm = s & m;
        diff = sm - dm;
        prod = diff * {24'd0, a};
        return (dm + (prod >> 8)) & m;
    endfunction

    // Expected new_pixel for one word under the given register values.
    function automatic logic [PIX_W-1:0] blend_pixel(input cfg_t c,
                                                     input logic [CMD_W-1:0] mode,
                                                     input logic [PIX_W-1:0] d,
                                                     input logic [PIX_W-1:0] s,
                                                     input logic [ALPHA_W-1:0] a);
        logic [PIX_W-1:0] d16;
        logic [PIX_W-1:0] sum;
        logic [PIX_W-1:0] combined;
        logic [PIX_W-1:0] src_a;
        logic [PIX_W-1:0] dest_a;
        logic [PIX_W-1:0] a_term;
        logic [PIX_W-1:0] rgb;
        colour_sel_t      col;
        if (!c.wide_pixels)
        begin
            d16 = d & 32'h0000FFFF;
            rgb = weigh_channel(d16, s, c.red_mask, a) | weigh_channel(d16, s, c.green_mask, a)
                | weigh_channel(d16, s, c.blue_mask, a);
            a_term = (c.alpha_mask != 0) ? weigh_channel(d16, s, c.alpha_mask, a) : '0;
            return (rgb | a_term) & 32'h0000FFFF;
        end
        dest_a = d & c.alpha_mask;
        sum = (dest_a >> c.alpha_shift) + {24'd0, a};
        combined = (sum >> 1) << c.alpha_shift;
        src_a = {24'd0, a} << c.alpha_shift;
        case (mode)
            MODE_BLEND_COMBINE: begin col = COL_BLEND; a_term = combined; end
            MODE_BLEND_DEST_A:  begin col = COL_BLEND; a_term = dest_a; end
            MODE_BLEND_SRC_A:   begin col = COL_BLEND; a_term = src_a; end
            MODE_COPY_SRC_A:    begin col = COL_COPY;  a_term = src_a; end
            MODE_COPY_DEST_A:   begin col = COL_COPY;  a_term = dest_a; end
            MODE_COPY_COMBINE:  begin col = COL_COPY;  a_term = combined; end
            MODE_COPY_OPAQUE:
            begin
                col = COL_COPY;
                a_term = {24'd0, ALPHA_OPAQUE} << c.alpha_shift;
            end
            MODE_KEEP_SRC_A:    begin col = COL_KEEP;  a_term = src_a; end
            MODE_KEEP_COMBINE:  begin col = COL_KEEP;  a_term = combined; end
            MODE_KEEP_COND:
            begin
                col = COL_KEEP;
                a_term = (dest_a == 0 || a == 0) ? '0 : combined;
            end
            default:            begin col = COL_COPY;  a_term = '0; end
        endcase
        if (c.alpha_mask == 0)
            a_term = '0;
        if (col == COL_BLEND && a != ALPHA_OPAQUE)
            rgb = weigh_channel(d, s, c.red_mask, a) | weigh_channel(d, s, c.green_mask, a)
                | weigh_channel(d, s, c.blue_mask, a);
        else if (col == COL_KEEP)
            rgb = d & (c.red_mask | c.green_mask | c.blue_mask);
        else
            rgb = s & (c.red_mask | c.green_mask | c.blue_mask);
        return rgb | a_term;
    endfunction

    // Clock and the single reset at the start
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #400_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: random stalls by phase, forced high during the long hold-off
    always @(posedge clk)
    begin
        int stall_pct;
        stall_pct = (idle_mode == IDLE_RECEIVER) ? 68 : (idle_mode == IDLE_BOTH) ? 23 : 0;
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Long hold-off, counted here: the sender keeps offering words meanwhile,
    // so both pipeline registers fill and in_stall has to rise.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Scoreboard. Register writes update the shadow, accepted words push their
    // expected pixel, accepted results are checked against the oldest one.
    // The output is checked before the push so a word never meets itself.
    always @(posedge clk)
    begin
        logic [PIX_W-1:0] want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDE_PIXELS: cfg_shadow.wide_pixels = cfg_data[0];
                    CFG_RED_MASK:    cfg_shadow.red_mask    = cfg_data;
                    CFG_GREEN_MASK:  cfg_shadow.green_mask  = cfg_data;
                    CFG_BLUE_MASK:   cfg_shadow.blue_mask   = cfg_data;
                    CFG_ALPHA_MASK:  cfg_shadow.alpha_mask  = cfg_data;
                    CFG_ALPHA_SHIFT: cfg_shadow.alpha_shift = cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: new_pixel %08h arrived with no word outstanding",
                             $time, new_pixel);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (new_pixel !== want)
                    begin
                        mismatch_count++;
                        $display("%0t ns: new_pixel expected %08h, actual %08h",
                                 $time, want, new_pixel);
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_pixels.push_back(has_typed_pixel ? typed_pixel
                    : blend_pixel(cfg_shadow, cmd, dest_pixel, src_color, alpha));
        end
    end

    // Offer one word, with a random gap first in the sender-idle phases, and
    // return at the edge that accepts it. Valid is only lowered for a gap.
    task automatic send_word(input logic [CMD_W-1:0] c, input logic [PIX_W-1:0] d,
                             input logic [PIX_W-1:0] s, input logic [ALPHA_W-1:0] a,
                             input logic known, input logic [PIX_W-1:0] known_pixel);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 68 : (idle_mode == IDLE_BOTH) ? 23 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        cmd <= c;
        dest_pixel <= d;
        src_color <= s;
        alpha <= a;
        has_typed_pixel <= known;
        typed_pixel <= known_pixel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Stop offering and let every outstanding word come out, plus a margin
    // past the two pipeline stages, before registers are touched.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        row_t             row;
        cfg_t             setting;
        idle_mode_t       phase_modes [4];
        logic [CMD_W-1:0] w_cmd;
        logic [PIX_W-1:0] w_dest;
        logic [ALPHA_W-1:0] w_alpha;

        phase_modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        wait (rst_n);
        @(posedge clk);

        // Directed table, no idling
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                drain();
                cfg_we <= 1'b1;
                cfg_index <= row.code[CFG_IDX_W-1:0];
                cfg_data <= row.dest;
                @(posedge clk);
                cfg_we <= 1'b0;
            end
            else
                send_word(row.code, row.dest, row.src, row.alpha, row.known, row.pixel);
        end

        // Random part: a series of pixel formats, each run through all four
        // idle phases. Formats: reset ARGB, RGB565, ARGB4444 (16-bit), all
        // masks full with shift 31, all masks empty with shift 0, ABGR, RGBA,
        // then fully random registers.
        for (int k = 0; k < SETTING_COUNT; k++)
        begin
            case (k)
                0: setting = '{RST_WIDE_PIXELS, RST_RED_MASK, RST_GREEN_MASK, RST_BLUE_MASK,
                               RST_ALPHA_MASK, RST_ALPHA_SHIFT};
                1: setting = '{1'b0, 32'h0000F800, 32'h000007E0, 32'h0000001F,
                               32'h00000000, 5'd0};
                2: setting = '{1'b0, 32'h00000F00, 32'h000000F0, 32'h0000000F,
                               32'h0000F000, 5'd12};
                3: setting = '{1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               32'hFFFFFFFF, 5'd31};
                4: setting = '{1'b1, 32'h00000000, 32'h00000000, 32'h00000000,
                               32'h00000000, 5'd0};
                5: setting = '{1'b1, 32'h000000FF, 32'h0000FF00, 32'h00FF0000,
                               32'hFF000000, 5'd24};
                6: setting = '{1'b1, 32'hFF000000, 32'h00FF0000, 32'h0000FF00,
                               32'h000000FF, 5'd0};
                default:
                begin
                    setting.wide_pixels = 1'($urandom_range(1));
                    setting.red_mask = $urandom;
                    setting.green_mask = $urandom;
                    setting.blue_mask = $urandom;
                    setting.alpha_mask = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
                    setting.alpha_shift = 5'($urandom_range(31));
                end
            endcase

            // Back-to-back writes of all six registers; junk in the unused
            // data bits of the narrow ones must be ignored.
            drain();
            cfg_we <= 1'b1;
            cfg_index <= CFG_WIDE_PIXELS;
            cfg_data <= ($urandom & ~32'd1) | {31'd0, setting.wide_pixels};
            @(posedge clk);
            cfg_index <= CFG_RED_MASK;
            cfg_data <= setting.red_mask;
            @(posedge clk);
            cfg_index <= CFG_GREEN_MASK;
            cfg_data <= setting.green_mask;
            @(posedge clk);
            cfg_index <= CFG_BLUE_MASK;
            cfg_data <= setting.blue_mask;
            @(posedge clk);
            cfg_index <= CFG_ALPHA_MASK;
            cfg_data <= setting.alpha_mask;
            @(posedge clk);
            cfg_index <= CFG_ALPHA_SHIFT;
            cfg_data <= ($urandom & ~32'h1F) | {27'd0, setting.alpha_shift};
            @(posedge clk);
            cfg_we <= 1'b0;

            for (int p = 0; p < 4; p++)
            begin
                idle_mode = phase_modes[p];
                if (k == 0 && p == 0)
                    hold_go <= 1'b1;
                repeat (WORDS_PER_PHASE)
                begin
                    // Mostly defined modes; alpha often at its extremes;
                    // dest alpha cleared now and then for the conditional keep
                    w_cmd = ($urandom_range(99) < 85) ? CMD_W'($urandom_range(9))
                                                     : CMD_W'($urandom_range(15));
                    case ($urandom_range(9))
                        0:       w_alpha = '0;
                        1:       w_alpha = ALPHA_OPAQUE;
                        default: w_alpha = ALPHA_W'($urandom_range(255));
                    endcase
                    w_dest = $urandom;
                    if ($urandom_range(3) == 0)
                        w_dest = w_dest & ~setting.alpha_mask;
                    send_word(w_cmd, w_dest, $urandom, w_alpha, 1'b0, '0);
                end
            end
        end

        // Wind down: wait for the last results, bounded
        in_valid <= 1'b0;
        idle_mode = IDLE_NONE;
        for (int i = 0; i < 2000 && pending_pixels.size() != 0; i++)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            mismatch_count += pending_pixels.size();
            $display("%0t ns: %0d expected new_pixel values never arrived",
                     $time, pending_pixels.size());
        end

        $display("Covered: %0d words over %0d register settings, 16- and 32-bit pixels,",
                 words_sent, SETTING_COUNT + 1);
        $display("all blend modes, idle and stall phases and a full-pipeline hold-off; %0d checked",
                 pixels_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
